[rtl/core/hftd_pkg.sv]
// Shared types and constants of the Huffman decode tree unit.
package hftd_pkg;

  localparam int OP_W         = 3;
  localparam int SYM_W        = 8;
  localparam int LEN_W        = 5;
  localparam int BITS_W       = 16;
  localparam int BIT_IDX_W    = $clog2(BITS_W);
  localparam int MAX_CODE_LEN = 16;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_INSERT  = 3'd0;
  localparam op_t OP_ROOT    = 3'd1;
  localparam op_t OP_LEFT    = 3'd2;
  localparam op_t OP_RIGHT   = 3'd3;
  localparam op_t OP_OBSERVE = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MV,
    ST_EVAL,
    ST_RD,
    ST_INS_CHK,
    ST_INS_NEW,
    ST_INS_SYM
  } state_t;

  typedef struct packed {
    logic present;
    logic room;
    logic leaf;
  } step_st_t;

endpackage

[rtl/core/hftd_if.sv]
// Input and result channel interfaces of the Huffman decode tree unit.
interface hftd_in_if import hftd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SYM_W-1:0]   code_symbol;
  logic [LEN_W-1:0]   code_length;
  logic [BITS_W-1:0]  code_bits;

  modport source (output valid, output op, output code_symbol, output code_length,
                  output code_bits, input ready);
  modport sink (input valid, input op, input code_symbol, input code_length,
                input code_bits, output ready);
endinterface

interface hftd_out_if import hftd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cursor_valid;
  logic              at_leaf;
  logic [SYM_W-1:0]  leaf_symbol;
  logic              table_full;

  modport source (output valid, output cursor_valid, output at_leaf, output leaf_symbol,
                  output table_full, input ready);
  modport sink (input valid, input cursor_valid, input at_leaf, input leaf_symbol,
                input table_full, output ready);
endinterface

[rtl/core/huffman_tree_decoder_unit.sv]
// Top level of the Huffman decode tree unit: sequencer, node RAM and output register.
//
// Input channel in_if (valid/ready) carries one item per beat: op, code_symbol,
// code_length, code_bits. Result channel out_if returns exactly one beat per item:
// cursor_valid, at_leaf, leaf_symbol, table_full.
// Nodes live in one RAM (one write, one registered read per cycle); a single step
// unit picks the child and checks presence and free space, reused for every bit.
// Items are handled one at a time; in_if.ready is high only while the sequencer idles.
// Steps per item: observe and reset cursor read the entry, then evaluate (ST_EVAL);
// go left or right reads the cursor entry (ST_MV), then the child, or evaluates at once
// from an invalid cursor; insert walks the path in ST_INS_CHK, adds each new node via
// ST_INS_NEW and a symbol on an existing end node via ST_INS_SYM, then rereads via ST_RD.
// Reset: all control state clears, then the init state writes the root entry; nodes
// beyond the fill count are never read, so no further clearing is needed.
// A stalled result sits in the output register; the unit accepts the next item
// and stalls only when a new result is ready while the previous one is not taken.
module huffman_tree_decoder_unit import hftd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic  clk,
  input  logic  rst_n,
  hftd_in_if.sink    in_if,
  hftd_out_if.source out_if
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int EW = 2 * AW + SYM_W + 2;
  localparam int HL = EW - 1;
  localparam int HR = EW - 2;
  localparam int LT = EW - 3;
  localparam int RT = EW - 3 - AW;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic              fresh_r, fresh_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic              ok_r, ok_nxt;
  logic              full_r, full_nxt;

  logic              ov_r, ov_nxt;
  logic              o_cv_r, o_cv_nxt;
  logic              o_leaf_r, o_leaf_nxt;
  logic [SYM_W-1:0]  o_sym_r, o_sym_nxt;
  logic              o_full_r, o_full_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  logic [EW-1:0]     ent;
  logic [EW-1:0]     wd_par;
  logic              code_bit;
  logic              dir;
  logic [AW-1:0]     child;
  step_st_t          stp;
  logic [LEN_W-1:0]  len_c;
  logic [AW-1:0]     new_idx;
  logic              in_acc;

  hftd_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent      = fresh_r ? '0 : ram_rdata;
  assign code_bit = (pos_r < LEN_W'(BITS_W)) ? bits_r[pos_r[BIT_IDX_W-1:0]] : 1'b0;
  assign dir      = (state_r == ST_MV) ? (op_r == OP_RIGHT) : code_bit;
  assign new_idx  = used_r[AW-1:0];
  assign len_c    = (in_if.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                             : in_if.code_length;

  hftd_step #(.NODE_COUNT(NODE_COUNT), .AW(AW), .CW(CW)) u_step (
    .has_l (ent[HL]),
    .has_r (ent[HR]),
    .left  (ent[LT -: AW]),
    .right (ent[RT -: AW]),
    .dir   (dir),
    .used  (used_r),
    .child (child),
    .st    (stp)
  );

  // parent entry with the new child linked in
  always_comb begin
    wd_par = ent;
    if (dir) begin
      wd_par[HR]      = 1'b1;
      wd_par[RT -: AW] = new_idx;
    end else begin
      wd_par[HL]      = 1'b1;
      wd_par[LT -: AW] = new_idx;
    end
  end

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    sym_nxt    = sym_r;
    bits_nxt   = bits_r;
    pos_nxt    = pos_r;
    node_nxt   = node_r;
    fresh_nxt  = 1'b0;
    used_nxt   = used_r;
    cur_nxt    = cur_r;
    ok_nxt     = ok_r;
    full_nxt   = full_r;
    ov_nxt     = ov_r && !out_if.ready;
    o_cv_nxt   = o_cv_r;
    o_leaf_nxt = o_leaf_r;
    o_sym_nxt  = o_sym_r;
    o_full_nxt = o_full_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_if.op;
          sym_nxt  = in_if.code_symbol;
          bits_nxt = in_if.code_bits;
          pos_nxt  = len_c - LEN_W'(1);
          case (in_if.op)
            OP_INSERT: begin
              if (len_c == '0) begin
                cur_nxt   = '0;
                ok_nxt    = 1'b1;
                state_nxt = ST_RD;
              end else begin
                node_nxt  = '0;
                ram_re    = 1'b1;
                state_nxt = ST_INS_CHK;
              end
            end
            OP_ROOT: begin
              cur_nxt   = '0;
              ok_nxt    = 1'b1;
              ram_re    = 1'b1;
              state_nxt = ST_EVAL;
            end
            OP_LEFT, OP_RIGHT: begin
              if (ok_r) begin
                ram_re    = 1'b1;
                ram_raddr = cur_r;
                state_nxt = ST_MV;
              end else begin
                state_nxt = ST_EVAL;
              end
            end
            default: begin
              ram_re    = 1'b1;
              ram_raddr = cur_r;
              state_nxt = ST_EVAL;
            end
          endcase
        end
      end
      ST_MV: begin
        if (stp.present) begin
          cur_nxt   = child;
          ram_re    = 1'b1;
          ram_raddr = child;
        end else begin
          ok_nxt = 1'b0;
        end
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt     = 1'b1;
          o_cv_nxt   = ok_r;
          o_leaf_nxt = ok_r && stp.leaf;
          o_sym_nxt  = (ok_r && stp.leaf) ? ent[SYM_W-1:0] : '0;
          o_full_nxt = full_r;
          state_nxt  = ST_IDLE;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_r;
        state_nxt = ST_EVAL;
      end
      ST_INS_CHK: begin
        if (stp.present) begin
          node_nxt  = child;
          ram_re    = 1'b1;
          ram_raddr = child;
          if (pos_r == '0) begin
            state_nxt = ST_INS_SYM;
          end else begin
            pos_nxt = pos_r - LEN_W'(1);
          end
        end else if (!stp.room) begin
          full_nxt  = 1'b1;
          cur_nxt   = '0;
          ok_nxt    = 1'b1;
          state_nxt = ST_RD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = node_r;
          ram_wdata = wd_par;
          state_nxt = ST_INS_NEW;
        end
      end
      ST_INS_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = new_idx;
        ram_wdata = {{(EW - SYM_W){1'b0}}, ((pos_r == '0) ? sym_r : {SYM_W{1'b0}})};
        used_nxt  = used_r + CW'(1);
        node_nxt  = new_idx;
        if (pos_r == '0) begin
          cur_nxt   = '0;
          ok_nxt    = 1'b1;
          state_nxt = ST_RD;
        end else begin
          pos_nxt   = pos_r - LEN_W'(1);
          fresh_nxt = 1'b1;
          state_nxt = ST_INS_CHK;
        end
      end
      ST_INS_SYM: begin
        ram_we    = 1'b1;
        ram_waddr = node_r;
        ram_wdata = {ent[EW-1:SYM_W], sym_r};
        cur_nxt   = '0;
        ok_nxt    = 1'b1;
        state_nxt = ST_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      used_r  <= CW'(1);
      cur_r   <= '0;
      ok_r    <= 1'b1;
      full_r  <= 1'b0;
      fresh_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      cur_r   <= cur_nxt;
      ok_r    <= ok_nxt;
      full_r  <= full_nxt;
      fresh_r <= fresh_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sym_r    <= sym_nxt;
    bits_r   <= bits_nxt;
    pos_r    <= pos_nxt;
    node_r   <= node_nxt;
    o_cv_r   <= o_cv_nxt;
    o_leaf_r <= o_leaf_nxt;
    o_sym_r  <= o_sym_nxt;
    o_full_r <= o_full_nxt;
  end

  assign out_if.valid        = ov_r;
  assign out_if.cursor_valid = o_cv_r;
  assign out_if.at_leaf      = o_leaf_r;
  assign out_if.leaf_symbol  = o_sym_r;
  assign out_if.table_full   = o_full_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready)
    else $error("input accepted while an item is in flight");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("table full flag dropped");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r <= CW'(NODE_COUNT)) && (used_r != '0))
    else $error("node fill count out of range");

  a_leaf_needs_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.cursor_valid) |-> (!out_if.at_leaf && out_if.leaf_symbol == '0))
    else $error("leaf reported for an invalid cursor");

endmodule

[rtl/core/hftd_ram.sv]
// Generic single write, single read RAM with registered read data.
module hftd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/hftd_step.sv]
// Shared tree step unit: child select, presence, free-node check and leaf test.
module hftd_step import hftd_pkg::*; #(
  parameter int NODE_COUNT = 512,
  parameter int AW         = 9,
  parameter int CW         = 10
) (
  input  logic          has_l,
  input  logic          has_r,
  input  logic [AW-1:0] left,
  input  logic [AW-1:0] right,
  input  logic          dir,
  input  logic [CW-1:0] used,
  output logic [AW-1:0] child,
  output step_st_t      st
);

  assign child      = dir ? right : left;
  assign st.present = dir ? has_r : has_l;
  assign st.room    = (used < CW'(NODE_COUNT));
  assign st.leaf    = !has_l && !has_r;

endmodule

[test/hftd_decode_checker.sv]
`timescale 1ns / 1ps
// Scoreboard of the Huffman decode tree unit: mirrors the node table and checks each result beat.
module hftd_decode_checker import hftd_pkg::*; #(
  parameter int NODES = 512
) (
  input  logic clk,
  input  logic rst_n,
  hftd_in_if   in_ch,
  hftd_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int IDX_W = $clog2(NODES);

  typedef struct packed {
    logic             cursor_valid;
    logic             at_leaf;
    logic [SYM_W-1:0] leaf_symbol;
    logic             table_full;
  } tree_view_t;

  logic [IDX_W-1:0] left_ptr [NODES];
  logic [IDX_W-1:0] right_ptr[NODES];
  bit               left_set [NODES];
  bit               right_set[NODES];
  logic [SYM_W-1:0] sym_at   [NODES];
  int               nodes_taken;
  logic [IDX_W-1:0] cursor;
  bit               cursor_live;
  bit               overflowed;
  tree_view_t       tree_view_q[$];
  int               errs;

  function automatic tree_view_t decode_step(op_t op, logic [SYM_W-1:0] sym,
                                             logic [LEN_W-1:0] len, logic [BITS_W-1:0] bits);
    int         n;
    int         depth;
    int         i;
    bit         path_ok;
    bit         go_right;
    tree_view_t v;
    n       = 0;
    path_ok = 1'b1;
    depth   = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
    case (op)
      OP_INSERT: begin
        for (i = depth - 1; i >= 0 && path_ok; i--) begin
          go_right = bits[i];
          if (go_right ? !right_set[n] : !left_set[n]) begin
            if (nodes_taken >= NODES) begin
              path_ok = 1'b0;
            end else begin
              if (go_right) begin
                right_set[n] = 1'b1;
                right_ptr[n] = IDX_W'(nodes_taken);
              end else begin
                left_set[n] = 1'b1;
                left_ptr[n] = IDX_W'(nodes_taken);
              end
              left_set[nodes_taken]  = 1'b0;
              right_set[nodes_taken] = 1'b0;
              sym_at[nodes_taken]    = '0;
              nodes_taken++;
            end
          end
          if (path_ok) n = go_right ? int'(right_ptr[n]) : int'(left_ptr[n]);
        end
        if (!path_ok) overflowed = 1'b1;
        else if (depth > 0) sym_at[n] = sym;
        cursor      = '0;
        cursor_live = 1'b1;
      end
      OP_ROOT: begin
        cursor      = '0;
        cursor_live = 1'b1;
      end
      OP_LEFT: begin
        if (cursor_live && left_set[cursor]) cursor = left_ptr[cursor];
        else cursor_live = 1'b0;
      end
      OP_RIGHT: begin
        if (cursor_live && right_set[cursor]) cursor = right_ptr[cursor];
        else cursor_live = 1'b0;
      end
      default: ;
    endcase
    v              = '0;
    v.cursor_valid = cursor_live;
    if (cursor_live && !left_set[cursor] && !right_set[cursor]) begin
      v.at_leaf     = 1'b1;
      v.leaf_symbol = sym_at[cursor];
    end
    v.table_full = overflowed;
    return v;
  endfunction

  always @(posedge clk) begin
    tree_view_t e;
    if (!rst_n) begin
      for (int k = 0; k < NODES; k++) begin
        left_ptr[k]  = '0;
        right_ptr[k] = '0;
        left_set[k]  = 1'b0;
        right_set[k] = 1'b0;
        sym_at[k]    = '0;
      end
      nodes_taken = 1;
      cursor      = '0;
      cursor_live = 1'b1;
      overflowed  = 1'b0;
      tree_view_q.delete();
      errs = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tree_view_q.size() == 0) begin
          $error("result beat with nothing expected");
          errs++;
        end else begin
          e = tree_view_q.pop_front();
          if (out_ch.cursor_valid !== e.cursor_valid) begin
            $error("cursor_valid: expected %0d, got %0d", e.cursor_valid, out_ch.cursor_valid);
            errs++;
          end
          if (out_ch.at_leaf !== e.at_leaf) begin
            $error("at_leaf: expected %0d, got %0d", e.at_leaf, out_ch.at_leaf);
            errs++;
          end
          if (out_ch.leaf_symbol !== e.leaf_symbol) begin
            $error("leaf_symbol: expected 0x%02h, got 0x%02h", e.leaf_symbol,
                   out_ch.leaf_symbol);
            errs++;
          end
          if (out_ch.table_full !== e.table_full) begin
            $error("table_full: expected %0d, got %0d", e.table_full, out_ch.table_full);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        tree_view_q.push_back(decode_step(in_ch.op, in_ch.code_symbol, in_ch.code_length,
                                          in_ch.code_bits));
    end
    pending    <= tree_view_q.size();
    fail_count <= errs;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the Huffman decode tree testbench: clock, reset, beat stimulus and verdict.
module testbench;
  import hftd_pkg::*;

  localparam int  TREE_NODES     = 512;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  SETTLE_CYCLES  = 60;
  localparam op_t OP_SPARE5      = 3'd5;
  localparam op_t OP_SPARE6      = 3'd6;
  localparam op_t OP_SPARE7      = 3'd7;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   sent;
  int   quiet;
  int   hold_left;
  int   long_left;
  bit   hold_go;
  bit   hold_done;

  logic [LEN_W-1:0]  code_len_q[$];
  logic [BITS_W-1:0] code_bits_q[$];

  hftd_in_if  in_if();
  hftd_out_if out_if();

  huffman_tree_decoder_unit #(.NODE_COUNT(TREE_NODES)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  hftd_decode_checker #(.NODES(TREE_NODES)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side backpressure, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input op_t op, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [BITS_W-1:0] bits);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.code_symbol <= sym;
    in_if.code_length <= len;
    in_if.code_bits   <= bits;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  // non-insert beat; the code fields are ignored but still toggled
  task automatic send_move(input op_t op);
    send_item(op, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(31)),
              BITS_W'($urandom_range(65535)));
  endtask

  task automatic add_code(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                          input logic [BITS_W-1:0] bits);
    send_item(OP_INSERT, sym, len, bits);
    if (len != 0) begin
      code_len_q.push_back((len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len);
      code_bits_q.push_back(bits);
    end
  endtask

  task automatic insert_random(input bit fill);
    int               r;
    logic [LEN_W-1:0] len;
    r = $urandom_range(99);
    if (fill) begin
      len = LEN_W'($urandom_range(14, 31));
    end else if (r < 4) begin
      len = '0;
    end else if (r < 14 && long_left > 0) begin
      len = LEN_W'($urandom_range(9, 31));
      long_left--;
    end else begin
      len = LEN_W'($urandom_range(1, 6));
    end
    add_code(SYM_W'($urandom_range(255)), len, BITS_W'($urandom_range(65535)));
  endtask

  // follow a stored code, usually from the root, sometimes cut short or run past its end
  task automatic walk_code();
    int                idx;
    int                steps;
    int                extra;
    int                i;
    logic [LEN_W-1:0]  len;
    logic [BITS_W-1:0] bits;
    bit                right;
    idx   = $urandom_range(code_len_q.size() - 1);
    len   = code_len_q[idx];
    bits  = code_bits_q[idx];
    steps = len;
    if ($urandom_range(3) == 0) steps = $urandom_range(len);
    extra = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(9) != 0) send_move(OP_ROOT);
    for (i = 0; i < steps + extra; i++) begin
      right = (i < steps) ? bits[len - 1 - i] : bit'($urandom_range(1));
      send_move(right ? OP_RIGHT : OP_LEFT);
    end
    if ($urandom_range(2) == 0) send_move(OP_OBSERVE);
  endtask

  task automatic run_items(input int upto);
    int r;
    while (sent < upto) begin
      r = $urandom_range(99);
      if (r < 65) walk_code();
      else if (r < 85) insert_random(1'b0);
      else send_move(op_t'($urandom_range(1, 7)));
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.op          = OP_OBSERVE;
    in_if.code_symbol = '0;
    in_if.code_length = '0;
    in_if.code_bits   = '0;
    rst_n             = 1'b0;
    tx_idle_pct       = 8;
    rx_stall_pct      = 73;
    long_left         = 16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty tree, moves into missing children, spare op codes
    send_move(OP_OBSERVE);
    send_move(OP_LEFT);
    send_move(OP_RIGHT);
    send_move(OP_SPARE7);
    send_move(OP_ROOT);
    add_code(8'hFF, 5'd0, 16'hFFFF);
    add_code(8'hA5, 5'd1, 16'h0000);
    add_code(8'hFF, 5'd16, 16'hFFFF);
    add_code(8'h3C, 5'd31, 16'h8001);
    // passes through the symbol-carrying left child
    add_code(8'h00, 5'd17, 16'h0000);
    send_move(OP_ROOT);
    send_move(OP_LEFT);
    send_move(OP_SPARE5);
    send_move(OP_RIGHT);
    send_move(OP_SPARE6);
    send_move(OP_ROOT);
    send_move(OP_RIGHT);
    send_move(OP_RIGHT);
    send_move(OP_LEFT);
    send_move(OP_LEFT);
    add_code(8'h81, 5'd1, 16'h0001);
    send_move(OP_OBSERVE);
    drain();

    run_items(620);
    drain();

    tx_idle_pct  = 73;
    rx_stall_pct = 8;
    hold_go      = 1'b1;
    run_items(1240);
    drain();

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // long codes until the node table runs out
    repeat (70) begin
      insert_random(1'b1);
      if ($urandom_range(1) == 0) walk_code();
    end
    run_items(1850);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
